[rtl/core/sawarq_pkg.sv]
// Shared types and constants for the stop-and-wait ARQ sender.
package sawarq_pkg;

   localparam int PAYLOAD_BYTES = 20;
   localparam int IDX_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PAYLOAD_BYTES - 1);

   localparam int BYTE_W = 8;
   localparam int ACKN_W = 20;
   localparam int CSUM_W = 13;
   localparam int TICK_W = 16;
   localparam logic [TICK_W-1:0] TIMEOUT_RESET = TICK_W'(20);

   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 24;

   typedef enum logic [1:0] {
      MODE_BYTE = 2'd0,
      MODE_ACK  = 2'd1,
      MODE_TICK = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      STAT_STORED  = 3'd0,
      STAT_REFUSED = 3'd1,
      STAT_SENT    = 3'd2,
      STAT_ACK_OK  = 3'd3,
      STAT_ACK_IGN = 3'd4,
      STAT_IDLE    = 3'd5
   } status_type;

   typedef enum logic {
      CTRL_IDLE,
      CTRL_SEND
   } ctrl_state_type;

   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_idx;
      logic [BYTE_W-1:0] wr_data;
      logic             rd_en;
      logic [IDX_W-1:0] rd_idx;
   } store_req_type;

   typedef struct packed {
      status_type        status;
      logic [BYTE_W-1:0] out_byte;
      logic              out_seq;
      logic              out_ack;
      logic [CSUM_W-1:0] out_checksum;
      logic              out_last;
   } rsp_item_type;

   typedef struct packed {
      logic [1:0] count;
      logic       pop;
   } q_stat_type;

endpackage

[rtl/core/sawarq_store.sv]
// Payload memory holding the packet bytes for retransmission.
module sawarq_store
   import sawarq_pkg::*;
(
   input  logic              clock,
   input  store_req_type     store_req,
   output logic [BYTE_W-1:0] rd_data
);

   logic [BYTE_W-1:0] payload_mem_ff [PAYLOAD_BYTES];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (store_req.wr_en) begin
         payload_mem_ff[store_req.wr_idx] <= store_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (store_req.rd_en) begin
         rd_data_ff <= payload_mem_ff[store_req.rd_idx];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/sawarq_outq.sv]
// Two-entry result queue that decouples the controller from the result channel.
module sawarq_outq
   import sawarq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  rsp_item_type push_item,
   input  logic         rsp_tready,
   output logic         rsp_valid,
   output rsp_item_type rsp_item,
   output q_stat_type   q_stat
);

   rsp_item_type slot_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   logic         pop;

   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_item  = slot_ff[rd_ptr_ff];
   assign pop       = rsp_valid && rsp_tready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign q_stat.count = count_ff;
   assign q_stat.pop   = pop;

endmodule

[rtl/core/sawarq_ctrl.sv]
// Protocol controller: sequence bit, ack wait, timer and packet send sequencing.
module sawarq_ctrl
   import sawarq_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [1:0]             req_tuser,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic                   csr_we,
   input  logic [TICK_W-1:0]      csr_wdata,
   output store_req_type          store_req,
   input  logic [BYTE_W-1:0]      store_rd_data,
   input  q_stat_type             q_stat,
   output logic                   push,
   output rsp_item_type           push_item
);

   ctrl_state_type    state_ff, state_in;
   logic              awaiting_ff, awaiting_in;
   logic              seq_ff, seq_in;
   logic [IDX_W-1:0]  fill_ff, fill_in;
   logic [CSUM_W-1:0] running_ff, running_in;
   logic [CSUM_W-1:0] pkt_csum_ff, pkt_csum_in;
   logic [TICK_W-1:0] tick_ff, tick_in;
   logic [TICK_W-1:0] timeout_ff;
   logic [IDX_W-1:0]  issue_idx_ff, issue_idx_in;
   logic              issue_done_ff, issue_done_in;
   logic              pend_ff, pend_in;
   logic              pend_last_ff, pend_last_in;

   logic              accept;
   logic [BYTE_W-1:0] data_byte;
   logic [ACKN_W-1:0] ack_number;
   logic [CSUM_W-1:0] sum_plus;
   logic [TICK_W-1:0] tick_next;
   logic              credit;

   assign data_byte  = req_tdata[BYTE_W-1:0];
   assign ack_number = req_tdata[BYTE_W+ACKN_W-1:BYTE_W];
   assign sum_plus   = running_ff + CSUM_W'(data_byte);
   assign tick_next  = tick_ff + TICK_W'(1);

   // A read may be issued when its data will find a free queue slot in the cycle after.
   assign credit = (({1'b0, q_stat.count} + {2'b00, pend_ff}) < 3'd2) || q_stat.pop;

   always_comb begin
      state_in      = state_ff;
      awaiting_in   = awaiting_ff;
      seq_in        = seq_ff;
      fill_in       = fill_ff;
      running_in    = running_ff;
      pkt_csum_in   = pkt_csum_ff;
      tick_in       = tick_ff;
      issue_idx_in  = issue_idx_ff;
      issue_done_in = issue_done_ff;
      pend_in       = 1'b0;
      pend_last_in  = pend_last_ff;
      store_req     = '0;
      push          = 1'b0;
      push_item     = '0;
      push_item.status   = STAT_IDLE;
      push_item.out_last = 1'b1;

      req_tready = (state_ff == CTRL_IDLE) && (q_stat.count != 2'd2);
      accept     = req_tvalid && req_tready;

      if (accept) begin
         case (mode_type'(req_tuser))
            MODE_BYTE: begin
               if (awaiting_ff) begin
                  push             = 1'b1;
                  push_item.status = STAT_REFUSED;
               end else begin
                  store_req.wr_en   = 1'b1;
                  store_req.wr_idx  = fill_ff;
                  store_req.wr_data = data_byte;
                  if (fill_ff == LAST_IDX) begin
                     pkt_csum_in   = sum_plus + {{(CSUM_W-2){1'b0}}, seq_ff, 1'b0};
                     fill_in       = '0;
                     running_in    = '0;
                     awaiting_in   = 1'b1;
                     tick_in       = '0;
                     state_in      = CTRL_SEND;
                     issue_idx_in  = '0;
                     issue_done_in = 1'b0;
                  end else begin
                     fill_in          = fill_ff + IDX_W'(1);
                     running_in       = sum_plus;
                     push             = 1'b1;
                     push_item.status = STAT_STORED;
                  end
               end
            end
            MODE_ACK: begin
               push = 1'b1;
               if (awaiting_ff && (ack_number == {{(ACKN_W-1){1'b0}}, seq_ff})) begin
                  awaiting_in      = 1'b0;
                  seq_in           = ~seq_ff;
                  tick_in          = '0;
                  push_item.status = STAT_ACK_OK;
               end else begin
                  push_item.status = STAT_ACK_IGN;
               end
            end
            MODE_TICK: begin
               if (awaiting_ff && (tick_next >= timeout_ff)) begin
                  tick_in       = '0;
                  state_in      = CTRL_SEND;
                  issue_idx_in  = '0;
                  issue_done_in = 1'b0;
               end else begin
                  if (awaiting_ff) begin
                     tick_in = tick_next;
                  end
                  push             = 1'b1;
                  push_item.status = STAT_IDLE;
               end
            end
            default: begin
               push             = 1'b1;
               push_item.status = STAT_IDLE;
            end
         endcase
      end

      if ((state_ff == CTRL_SEND) && !issue_done_ff && credit) begin
         store_req.rd_en  = 1'b1;
         store_req.rd_idx = issue_idx_ff;
         pend_in          = 1'b1;
         pend_last_in     = (issue_idx_ff == LAST_IDX);
         if (issue_idx_ff == LAST_IDX) begin
            issue_done_in = 1'b1;
         end else begin
            issue_idx_in = issue_idx_ff + IDX_W'(1);
         end
      end

      if (pend_ff) begin
         push                   = 1'b1;
         push_item.status       = STAT_SENT;
         push_item.out_byte     = store_rd_data;
         push_item.out_seq      = seq_ff;
         push_item.out_ack      = seq_ff;
         push_item.out_checksum = pkt_csum_ff;
         push_item.out_last     = pend_last_ff;
         if (pend_last_ff) begin
            state_in = CTRL_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= CTRL_IDLE;
         awaiting_ff   <= 1'b0;
         seq_ff        <= 1'b0;
         fill_ff       <= '0;
         running_ff    <= '0;
         pkt_csum_ff   <= '0;
         tick_ff       <= '0;
         timeout_ff    <= TIMEOUT_RESET;
         issue_idx_ff  <= '0;
         issue_done_ff <= 1'b1;
         pend_ff       <= 1'b0;
         pend_last_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         awaiting_ff   <= awaiting_in;
         seq_ff        <= seq_in;
         fill_ff       <= fill_in;
         running_ff    <= running_in;
         pkt_csum_ff   <= pkt_csum_in;
         tick_ff       <= tick_in;
         issue_idx_ff  <= issue_idx_in;
         issue_done_ff <= issue_done_in;
         pend_ff       <= pend_in;
         pend_last_ff  <= pend_last_in;
         if (csr_we) begin
            timeout_ff <= csr_wdata;
         end
      end
   end

endmodule

[rtl/core/stop_and_wait_arq_sender.sv]
// Top level of the stop-and-wait (alternating bit) ARQ sender.
//
// Items enter on the req_ stream: tuser selects a message byte, an
// acknowledgment or a timer tick. Results leave on the rsp_ stream, one or
// more per input item, with tlast marking the final result of each input.
// Message bytes are kept in a payload memory; when the last byte of a
// packet arrives the whole packet is read back and sent, one byte per cycle
// at best, tagged with the sequence bit and the packet checksum. A timeout
// tick while an ack is awaited sends the stored packet again.
// One single-result item can enter every cycle while the result side keeps
// up. An item that starts a packet send holds the input until the last byte
// enters the result queue, with one payload memory read per output byte
// and the read data arriving in the cycle after the address.
// A two-entry result queue lets a new item enter while a result still waits.
// When the receiver stalls, the queue fills, memory reads pause and
// req_tready drops; nothing is lost or repeated.
// Reset clears the sequence bit, ack wait, fill count, sums and tick count
// and sets the timeout to 20 ticks. The payload memory is not cleared.
// Write the timeout register via csr_we, csr_wdata only while idle; not enforced.
module stop_and_wait_arq_sender
   import sawarq_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // data_byte[7:0], ack_number[27:8], zero pad
   input  logic [1:0]             req_tuser,  // mode[1:0]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,  // out_byte[7:0], out_seq[8], out_ack[9],
                                              // out_checksum[22:10], zero pad
   output logic [2:0]             rsp_tuser,  // status[2:0]
   output logic                   rsp_tlast,
   input  logic                   csr_we,
   input  logic [TICK_W-1:0]      csr_wdata
);

   store_req_type     store_req;
   logic [BYTE_W-1:0] store_rd_data;
   q_stat_type        q_stat;
   logic              push;
   rsp_item_type      push_item;
   rsp_item_type      rsp_item;

   // Controller owns all scalar protocol state and sequences the packet reads.
   sawarq_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tuser     (req_tuser),
      .req_tdata     (req_tdata),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .store_req     (store_req),
      .store_rd_data (store_rd_data),
      .q_stat        (q_stat),
      .push          (push),
      .push_item     (push_item)
   );

   // Payload memory: written as bytes arrive, read back during a send.
   sawarq_store u_store (
      .clock     (clock),
      .store_req (store_req),
      .rd_data   (store_rd_data)
   );

   // Result queue in front of the output channel.
   sawarq_outq u_outq (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .rsp_tready (rsp_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp_item   (rsp_item),
      .q_stat     (q_stat)
   );

   // Pack the result fields, lowest field in the lowest bits.
   assign rsp_tdata = {1'b0, rsp_item.out_checksum, rsp_item.out_ack,
                       rsp_item.out_seq, rsp_item.out_byte};
   assign rsp_tuser = rsp_item.status;
   assign rsp_tlast = rsp_item.out_last;

endmodule

[rtl/core/sawarq_check.sv]
// Port-level checker for the stop-and-wait ARQ sender, bound to the top level.
module sawarq_check
   import sawarq_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,
   input logic [2:0]             rsp_tuser,
   input logic                   rsp_tlast
);

   // A stalled result holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)
         && $stable(rsp_tlast))
      else $error("stalled result changed");

   // Only packet bytes come as multi-result runs.
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != STAT_SENT) |-> rsp_tlast)
      else $error("non-packet result without tlast");

   // The ack field of a sent byte always mirrors its sequence bit.
   a_seq_ack: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == STAT_SENT) |-> (rsp_tdata[8] == rsp_tdata[9]))
      else $error("ack field differs from sequence bit");

   // No input is taken while a packet is still going out.
   a_no_accept_mid_packet: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == STAT_SENT) && !rsp_tlast |-> !req_tready)
      else $error("input accepted during packet send");

endmodule

bind stop_and_wait_arq_sender sawarq_check u_sawarq_check (.*);

[dv/stop_and_wait_arq_sender_tb.sv]
// Self-checking testbench for the stop-and-wait ARQ sender.
`timescale 1ns / 1ps

module stop_and_wait_arq_sender_tb;
   import sawarq_pkg::*;

   // The mode field has no enum member for its spare code.
   localparam logic [1:0] MODE_SPARE = 2'd3;
   localparam int CYCLE_LIMIT = 500000;
   localparam int PHASE_ITEMS = 35;

   // One input item as the sender sees it, plus a flag that holds it back
   // until every outstanding result has been received.
   typedef struct {
      logic [1:0]        mode;
      logic [BYTE_W-1:0] data;
      logic [ACKN_W-1:0] ackn;
      bit                hold;
   } arq_input_t;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [1:0]             req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [2:0]             rsp_tuser;
   logic                   rsp_tlast;
   logic                   csr_we = 1'b0;
   logic [TICK_W-1:0]      csr_wdata = '0;

   stop_and_wait_arq_sender u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // Items waiting to be driven, and results the sender still owes us.
   arq_input_t   pending_q[$];
   rsp_item_type expected_rsp_q[$];

   int  mismatch_count = 0;
   int  cycle_count = 0;
   logic req_took = 1'b0;
   logic rsp_took = 1'b0;
   bit  send_quiet = 1'b0;
   bit  recv_quiet = 1'b0;
   int  send_wait = 0;
   int  recv_wait = 0;

   // Predicted sender state, updated on every accepted item.
   logic [BYTE_W-1:0] mdl_store [PAYLOAD_BYTES];
   bit                mdl_waiting = 1'b0;
   logic              mdl_seq = 1'b0;
   int                mdl_fill = 0;
   logic [CSUM_W-1:0] mdl_sum = '0;
   logic [CSUM_W-1:0] mdl_pkt_sum = '0;
   logic [TICK_W-1:0] mdl_ticks = '0;
   logic [TICK_W-1:0] mdl_timeout = TIMEOUT_RESET;

   // Stimulus-side view of the protocol, so that generated acks can match.
   bit   gen_waiting = 1'b0;
   logic gen_seq = 1'b0;
   int   gen_fill = 0;
   int   phase_effect = 0;

   task automatic report_mismatch(input string msg);
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
      mismatch_count++;
   endtask

   function automatic int draw_wait(input bit quiet);
      return quiet ? 0 : $urandom_range(0, 11);
   endfunction

   task automatic expect_single(input status_type status);
      rsp_item_type r;
      r = '0;
      r.status = status;
      r.out_last = 1'b1;
      expected_rsp_q.push_back(r);
   endtask

   // Every send replays the whole stored packet and restarts the timer.
   task automatic expect_packet();
      rsp_item_type r;
      for (int k = 0; k < PAYLOAD_BYTES; k++) begin
         r.status = STAT_SENT;
         r.out_byte = mdl_store[k];
         r.out_seq = mdl_seq;
         r.out_ack = mdl_seq;
         r.out_checksum = mdl_pkt_sum;
         r.out_last = (k == PAYLOAD_BYTES - 1);
         expected_rsp_q.push_back(r);
      end
      mdl_ticks = '0;
   endtask

   task automatic sender_step(input logic [1:0] mode, input logic [BYTE_W-1:0] data,
                              input logic [ACKN_W-1:0] ackn);
      case (mode)
         MODE_BYTE: begin
            if (mdl_waiting) begin
               expect_single(STAT_REFUSED);
            end else begin
               mdl_store[mdl_fill] = data;
               mdl_sum = mdl_sum + CSUM_W'(data);
               mdl_fill++;
               if (mdl_fill < PAYLOAD_BYTES) begin
                  expect_single(STAT_STORED);
               end else begin
                  // The header adds seq and ack, which are equal.
                  mdl_pkt_sum = mdl_sum + CSUM_W'({mdl_seq, 1'b0});
                  mdl_fill = 0;
                  mdl_sum = '0;
                  mdl_waiting = 1'b1;
                  expect_packet();
               end
            end
         end
         MODE_ACK: begin
            if (mdl_waiting && ackn == ACKN_W'(mdl_seq)) begin
               mdl_waiting = 1'b0;
               mdl_seq = ~mdl_seq;
               mdl_ticks = '0;
               expect_single(STAT_ACK_OK);
            end else begin
               expect_single(STAT_ACK_IGN);
            end
         end
         MODE_TICK: begin
            if (mdl_waiting) begin
               mdl_ticks = mdl_ticks + 1'b1;
               // A timeout of zero fires on the first tick, like a timeout of one.
               if (mdl_ticks >= mdl_timeout) expect_packet();
               else expect_single(STAT_IDLE);
            end else begin
               expect_single(STAT_IDLE);
            end
         end
         default: begin
            expect_single(STAT_IDLE);
         end
      endcase
   endtask

   // Queues one item and tracks what it will do to the sender, counting
   // only items that change its state.
   task automatic queue_item(input logic [1:0] mode, input logic [BYTE_W-1:0] data,
                             input logic [ACKN_W-1:0] ackn, input bit hold);
      arq_input_t it;
      it.mode = mode;
      it.data = data;
      it.ackn = ackn;
      it.hold = hold;
      pending_q.push_back(it);
      if (mode == MODE_BYTE && !gen_waiting) begin
         phase_effect++;
         gen_fill++;
         if (gen_fill == PAYLOAD_BYTES) begin
            gen_fill = 0;
            gen_waiting = 1'b1;
         end
      end else if (mode == MODE_ACK && gen_waiting && ackn == ACKN_W'(gen_seq)) begin
         phase_effect++;
         gen_waiting = 1'b0;
         gen_seq = ~gen_seq;
      end else if (mode == MODE_TICK && gen_waiting) begin
         phase_effect++;
      end
   endtask

   function automatic logic [BYTE_W-1:0] pick_byte();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return BYTE_W'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [ACKN_W-1:0] pick_ackn();
      return ACKN_W'($urandom_range(0, (1 << ACKN_W) - 1));
   endfunction

   // One item that may disturb a sender waiting for its ack: mostly ticks,
   // otherwise refused bytes, wrong acks or plain noise.
   task automatic queue_disturbance();
      case ($urandom_range(0, 9))
         6: queue_item(MODE_BYTE, pick_byte(), pick_ackn(), 1'b0);
         7: begin
            if ($urandom_range(0, 1) == 0)
               queue_item(MODE_ACK, pick_byte(), ACKN_W'(~gen_seq), 1'b0);
            else
               queue_item(MODE_ACK, pick_byte(), pick_ackn(), 1'b0);
         end
         8: queue_item(MODE_SPARE, pick_byte(), pick_ackn(), 1'b0);
         9: queue_item(2'($urandom_range(0, 3)), pick_byte(), pick_ackn(), 1'b0);
         default: queue_item(MODE_TICK, pick_byte(), pick_ackn(), 1'b0);
      endcase
   endtask

   // A well-formed exchange with random content: fill a packet, wait a
   // while amid disturbances, then usually acknowledge it.
   task automatic queue_exchange();
      bit hold;
      bit first;
      if (!gen_waiting) begin
         if ($urandom_range(0, 4) == 0) queue_disturbance();
         hold = ($urandom_range(0, 7) == 0);
         first = 1'b1;
         while (!gen_waiting) begin
            queue_item(MODE_BYTE, pick_byte(), pick_ackn(), hold && first);
            first = 1'b0;
         end
      end
      repeat ($urandom_range(0, 6)) queue_disturbance();
      if ($urandom_range(0, 6) != 0)
         queue_item(MODE_ACK, pick_byte(), ACKN_W'(gen_seq), 1'b0);
   endtask

   // Idle means every item is taken and every result has come back. The
   // extra cycles cover a packet read that may still be in flight.
   task automatic wait_idle();
      while (pending_q.size() != 0 || req_tvalid || expected_rsp_q.size() != 0)
         @(posedge clock);
      repeat (PAYLOAD_BYTES + 2) @(posedge clock);
   endtask

   task automatic set_timeout(input logic [TICK_W-1:0] value);
      wait_idle();
      @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Driver: presents queued items at the falling edge and keeps an item
   // steady until the sender takes it, then idles for a drawn gap.
   always @(negedge clock) begin : drive_req
      arq_input_t it;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_took) begin
         if (send_wait > 0) begin
            send_wait--;
            req_tvalid <= 1'b0;
         end else if (pending_q.size() != 0 &&
                      !(pending_q[0].hold && expected_rsp_q.size() != 0)) begin
            it = pending_q.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= {4'b0, it.ackn, it.data};
            req_tuser <= it.mode;
            send_wait = draw_wait(send_quiet);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: after each result taken, stalls for a drawn number of cycles.
   always @(negedge clock) begin : drive_rsp_ready
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_took) recv_wait = draw_wait(recv_quiet);
         if (recv_wait > 0) begin
            recv_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Monitor: predicts on every accepted item and checks every accepted
   // result against the oldest prediction.
   always @(posedge clock) begin : monitor
      rsp_item_type want;
      req_took <= req_tvalid && req_tready;
      rsp_took <= rsp_tvalid && rsp_tready;
      if (!reset) begin
         cycle_count++;
         if (csr_we) mdl_timeout = csr_wdata;
         if (req_tvalid && req_tready)
            sender_step(req_tuser, req_tdata[7:0], req_tdata[27:8]);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_rsp_q.size() == 0) begin
               report_mismatch($sformatf("result with status %0d while none expected",
                                         rsp_tuser));
            end else begin
               want = expected_rsp_q.pop_front();
               if (rsp_tuser !== want.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_tuser, want.status));
               if (rsp_tdata[7:0] !== want.out_byte)
                  report_mismatch($sformatf("out_byte %0h, expected %0h",
                                            rsp_tdata[7:0], want.out_byte));
               if (rsp_tdata[8] !== want.out_seq)
                  report_mismatch($sformatf("out_seq %0b, expected %0b",
                                            rsp_tdata[8], want.out_seq));
               if (rsp_tdata[9] !== want.out_ack)
                  report_mismatch($sformatf("out_ack %0b, expected %0b",
                                            rsp_tdata[9], want.out_ack));
               if (rsp_tdata[22:10] !== want.out_checksum)
                  report_mismatch($sformatf("out_checksum %0d, expected %0d",
                                            rsp_tdata[22:10], want.out_checksum));
               if (rsp_tlast !== want.out_last)
                  report_mismatch($sformatf("out_last %0b, expected %0b",
                                            rsp_tlast, want.out_last));
            end
         end
         if (cycle_count >= CYCLE_LIMIT) begin
            $display("stop_and_wait_arq_sender_tb NOT OK");
            $finish;
         end
      end
   end

   initial begin : stimulus
      logic [TICK_W-1:0] timeouts [6];
      timeouts = '{16'd1, 16'd0, 16'hFFFF, 16'd3, 16'd2, 16'd7};
      timeouts[4] = TICK_W'($urandom_range(2, 9));

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed opening under the reset timeout: the idle corner cases,
      // one packet with extreme bytes, then the waiting corner cases.
      queue_item(MODE_SPARE, 8'hFF, 20'hFFFFF, 1'b0);
      queue_item(MODE_TICK, 8'h00, 20'h00000, 1'b0);
      queue_item(MODE_ACK, 8'h00, 20'h00000, 1'b0);
      queue_item(MODE_BYTE, 8'h00, 20'h00000, 1'b1);
      repeat (PAYLOAD_BYTES - 2) queue_item(MODE_BYTE, 8'hFF, 20'h00000, 1'b0);
      queue_item(MODE_BYTE, 8'h80, 20'hFFFFF, 1'b0);
      queue_item(MODE_BYTE, 8'h5A, 20'h00000, 1'b0);
      queue_item(MODE_ACK, 8'h00, 20'h00001, 1'b0);
      queue_item(MODE_TICK, 8'h00, 20'h00000, 1'b0);
      queue_item(MODE_ACK, 8'h00, 20'h00000, 1'b1);

      // Random phases, each setting a timeout and an idling pattern first.
      foreach (timeouts[i]) begin
         set_timeout(timeouts[i]);
         send_quiet = (i == 1) || (i == 4);
         recv_quiet = (i == 3) || (i == 4);
         phase_effect = 0;
         while (phase_effect < PHASE_ITEMS) queue_exchange();
      end

      wait_idle();
      repeat (40) @(posedge clock);
      if (expected_rsp_q.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", expected_rsp_q.size()));
      if (mismatch_count == 0)
         $display("stop_and_wait_arq_sender_tb OK");
      else
         $display("stop_and_wait_arq_sender_tb NOT OK");
      $finish;
   end

endmodule
